// ===== rtl/core/fixed_weight_support_sampler_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the fixed weight support sampler
// Shared shorthand for the concurrent checks in the checker module.
// ---------------------------------------------------------------------------
`ifndef FIXED_WEIGHT_SUPPORT_SAMPLER_DEFINES_SVH
`define FIXED_WEIGHT_SUPPORT_SAMPLER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define FWSS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FWSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/fwss_pkg.sv =====
// ---------------------------------------------------------------------------
// fwss_pkg
// Shared constants, types and state encoding of the support sampler.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package fwss_pkg;

  localparam int VECTOR_LENGTH_DEF = 17669;
  localparam int MAX_WEIGHT_DEF    = 128;

  localparam int RAND_W   = 24;
  localparam int TARGET_W = 8;
  localparam int POS_W    = 15;
  localparam int WIDX_W   = 9;
  localparam int BIT_W    = 6;
  localparam int ENTRY_W  = 7;

  localparam logic [TARGET_W-1:0] TARGET_RESET = 8'd66;

  typedef struct packed {
    logic               last;
    logic [ENTRY_W-1:0] entry_number;
    logic [BIT_W-1:0]   bit_in_word;
    logic [WIDX_W-1:0]  word_index;
    logic [POS_W-1:0]   position;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_SCAN,
    ST_EMIT
  } fwss_state_t;

endpackage

// ===== rtl/core/fwss_reduce.sv =====
// ---------------------------------------------------------------------------
// fwss_reduce
// Three-stage Barrett reduction of a 24-bit word modulo VECTOR_LENGTH.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fwss_reduce import fwss_pkg::*; #(
  parameter int VECTOR_LENGTH = VECTOR_LENGTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [RAND_W-1:0]                   word,
  output logic                                done,
  output logic [$clog2(VECTOR_LENGTH)-1:0]    pos
);

  localparam longint unsigned MU = (64'd1 << 32) / VECTOR_LENGTH;
  localparam int MUW   = $clog2(MU + 1);
  localparam int PRODW = RAND_W + MUW;
  localparam int QW    = PRODW - 32;
  localparam int NW    = $clog2(VECTOR_LENGTH + 1);
  localparam int QNW   = QW + NW;
  localparam int PW    = $clog2(VECTOR_LENGTH);

  logic              va_r, vb_r, vc_r;
  logic [PRODW-1:0]  prod_r, prod_nxt;
  logic [RAND_W-1:0] xa_r, xb_r;
  logic [QNW-1:0]    qn_r, qn_nxt;
  logic [RAND_W-1:0] rem;
  logic [PW-1:0]     pos_r, pos_nxt;

  always_comb begin
    prod_nxt = PRODW'(word) * PRODW'(MU);
    qn_nxt   = QNW'(prod_r[PRODW-1:32]) * QNW'(VECTOR_LENGTH);
    // remainder lies below twice the modulus: one correction step
    rem      = xb_r - RAND_W'(qn_r);
    if (rem >= RAND_W'(VECTOR_LENGTH)) begin
      pos_nxt = PW'(rem - RAND_W'(VECTOR_LENGTH));
    end else begin
      pos_nxt = PW'(rem);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      va_r <= start;
      vb_r <= va_r;
      vc_r <= vb_r;
    end
    if (start) begin
      prod_r <= prod_nxt;
      xa_r   <= word;
    end
    if (va_r) begin
      qn_r <= qn_nxt;
      xb_r <= xa_r;
    end
    if (vb_r) begin
      pos_r <= pos_nxt;
    end
  end

  assign done = vc_r;
  assign pos  = pos_r;

endmodule

// ===== rtl/core/fwss_mem.sv =====
// ---------------------------------------------------------------------------
// fwss_mem
// Position store: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fwss_mem #(
  parameter int DEPTH = 128,
  parameter int AW    = 7,
  parameter int DW    = 15
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem_r [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/fwss_ctrl.sv =====
// ---------------------------------------------------------------------------
// fwss_ctrl
// Sequencer: rejection test, duplicate scan over the store, set counting.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fwss_ctrl import fwss_pkg::*; #(
  parameter int VECTOR_LENGTH = VECTOR_LENGTH_DEF,
  parameter int MAX_WEIGHT    = MAX_WEIGHT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic [RAND_W-1:0]                   in_word,
  output logic                                in_ready,
  input  logic [TARGET_W-1:0]                 target,
  output logic                                red_start,
  input  logic                                red_done,
  input  logic [$clog2(VECTOR_LENGTH)-1:0]    red_pos,
  output logic                                mem_wr_en,
  output logic [((MAX_WEIGHT > 1) ? $clog2(MAX_WEIGHT) : 1)-1:0] mem_wr_addr,
  output logic [$clog2(VECTOR_LENGTH)-1:0]    mem_wr_data,
  output logic                                mem_rd_en,
  output logic [((MAX_WEIGHT > 1) ? $clog2(MAX_WEIGHT) : 1)-1:0] mem_rd_addr,
  input  logic [$clog2(VECTOR_LENGTH)-1:0]    mem_rd_data,
  input  logic                                out_free,
  output logic                                emit,
  output out_item_t                           emit_item
);

  localparam int PW  = $clog2(VECTOR_LENGTH);
  localparam int AW  = (MAX_WEIGHT > 1) ? $clog2(MAX_WEIGHT) : 1;
  localparam int CAP = (MAX_WEIGHT < 255) ? MAX_WEIGHT : 255;
  localparam int CW  = $clog2(CAP + 1);
  localparam longint unsigned THRESH =
    ((64'd1 << RAND_W) / VECTOR_LENGTH) * VECTOR_LENGTH;

  fwss_state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_inc;
  logic [PW-1:0] pos_r;
  logic          below_thr, hit, scan_end, last;
  logic [TARGET_W-1:0] tgt;
  logic [15:0]   pos16;

  always_comb begin
    below_thr = ({1'b0, in_word} < (RAND_W + 1)'(THRESH));
    idx_inc   = idx_r + CW'(1);
    hit       = (mem_rd_data == pos_r);
    scan_end  = (idx_inc == count_r);
    // zero counts as one, anything past the store depth or 255 is clipped
    if (target == '0) begin
      tgt = TARGET_W'(1);
    end else if (target > TARGET_W'(CAP)) begin
      tgt = TARGET_W'(CAP);
    end else begin
      tgt = target;
    end
    last      = (({1'b0, TARGET_W'(count_r)} + 9'd1) >= {1'b0, tgt});
    count_nxt = last ? '0 : CW'(count_r + CW'(1));
    pos16     = 16'(pos_r);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && below_thr) state_nxt = ST_REDUCE;
      end
      ST_REDUCE: begin
        if (red_done) state_nxt = (count_r == '0) ? ST_EMIT : ST_SCAN;
      end
      ST_SCAN: begin
        if (hit) begin
          state_nxt = ST_IDLE;
        end else if (scan_end) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready    = 1'b0;
    red_start   = 1'b0;
    mem_rd_en   = 1'b0;
    mem_rd_addr = '0;
    mem_wr_en   = 1'b0;
    emit        = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        red_start = in_valid && below_thr;
      end
      ST_REDUCE: begin
        mem_rd_en = red_done && (count_r != '0);
      end
      ST_SCAN: begin
        if (!hit && !scan_end) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = AW'(idx_inc);
        end
      end
      ST_EMIT: begin
        mem_wr_en = out_free;
        emit      = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign mem_wr_addr = AW'(count_r);
  assign mem_wr_data = pos_r;

  assign emit_item.position     = pos16[POS_W-1:0];
  assign emit_item.word_index   = pos16[BIT_W +: WIDX_W];
  assign emit_item.bit_in_word  = pos16[BIT_W-1:0];
  assign emit_item.entry_number = ENTRY_W'(count_r);
  assign emit_item.last         = last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (emit) count_r <= count_nxt;
    end
    if (state_r == ST_REDUCE && red_done) begin
      pos_r <= red_pos;
      idx_r <= '0;
    end else if (state_r == ST_SCAN) begin
      idx_r <= idx_inc;
    end
  end

endmodule

// ===== rtl/core/fixed_weight_support_sampler.sv =====
// ---------------------------------------------------------------------------
// fixed_weight_support_sampler
// Rejection sampler producing distinct positions for fixed-weight supports.
// ---------------------------------------------------------------------------
// Usage notes:
//   in_*  : one 24-bit random word per request (byte0 in bits 7:0).
//   out_* : one position per kept, non-duplicate request, tlast marks the set's end.
//   cfg_* : target weight write, always ready, to be done while idle.
// A word at or above the rejection threshold is taken while idle and
// produces nothing. A kept word passes the three-stage Barrett reducer, then
// the stored positions of the current set are read one per cycle from the
// store. A new position goes to the output register once the scan ends
// without a match, or straight from the reducer for a set's first entry;
// no new request is taken until the sampler is back in idle. A duplicate
// returns to idle as soon as it matches a stored entry, with no output.
// Reset clears the set count and loads a target weight of 66; the store
// needs no clearing. If the receiver stalls, the result waits in the output
// register while the next request is taken and worked on; it only waits to
// be emitted once the register is still full.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fixed_weight_support_sampler import fwss_pkg::*; #(
  parameter int VECTOR_LENGTH = VECTOR_LENGTH_DEF,
  parameter int MAX_WEIGHT    = MAX_WEIGHT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [RAND_W-1:0]   in_tdata,   // [23:0] random_word
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [39:0]         out_tdata,  // [14:0] position, [23:15] word_index,
                                          // [29:24] bit_in_word, [36:30] entry_number
  output logic                out_tlast,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [TARGET_W-1:0] cfg_data    // target_weight
);

  localparam int PW = $clog2(VECTOR_LENGTH);
  localparam int AW = (MAX_WEIGHT > 1) ? $clog2(MAX_WEIGHT) : 1;

  logic [TARGET_W-1:0] target_r;
  logic                red_start, red_done;
  logic [PW-1:0]       red_pos;
  logic                mem_wr_en, mem_rd_en;
  logic [AW-1:0]       mem_wr_addr, mem_rd_addr;
  logic [PW-1:0]       mem_wr_data, mem_rd_data;
  logic                out_free, emit;
  out_item_t           emit_item;
  logic                out_valid_r;
  out_item_t           out_item_r;

  fwss_reduce #(
    .VECTOR_LENGTH(VECTOR_LENGTH)
  ) u_reduce (
    .clk  (clk),
    .rst_n(rst_n),
    .start(red_start),
    .word (in_tdata),
    .done (red_done),
    .pos  (red_pos)
  );

  fwss_mem #(
    .DEPTH(MAX_WEIGHT),
    .AW   (AW),
    .DW   (PW)
  ) u_mem (
    .clk    (clk),
    .wr_en  (mem_wr_en),
    .wr_addr(mem_wr_addr),
    .wr_data(mem_wr_data),
    .rd_en  (mem_rd_en),
    .rd_addr(mem_rd_addr),
    .rd_data(mem_rd_data)
  );

  fwss_ctrl #(
    .VECTOR_LENGTH(VECTOR_LENGTH),
    .MAX_WEIGHT   (MAX_WEIGHT)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_word    (in_tdata),
    .in_ready   (in_tready),
    .target     (target_r),
    .red_start  (red_start),
    .red_done   (red_done),
    .red_pos    (red_pos),
    .mem_wr_en  (mem_wr_en),
    .mem_wr_addr(mem_wr_addr),
    .mem_wr_data(mem_wr_data),
    .mem_rd_en  (mem_rd_en),
    .mem_rd_addr(mem_rd_addr),
    .mem_rd_data(mem_rd_data),
    .out_free   (out_free),
    .emit       (emit),
    .emit_item  (emit_item)
  );

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r    <= TARGET_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) target_r <= cfg_data;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (emit) out_item_r <= emit_item;
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_item_r.last;
  assign out_tdata  = {3'b000, out_item_r.entry_number, out_item_r.bit_in_word,
                       out_item_r.word_index, out_item_r.position};

endmodule

// ===== rtl/core/fwss_checker.sv =====
// ---------------------------------------------------------------------------
// fwss_checker
// Port-level checks on the support sampler, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "fixed_weight_support_sampler_defines.svh"

module fwss_checker import fwss_pkg::*; #(
  parameter int VECTOR_LENGTH = VECTOR_LENGTH_DEF
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tlast
);

  // a stalled result keeps its content
  `FWSS_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast), "fwss: result changed under stall")

  // word index and bit number are slices of the position
  `FWSS_ASSERT_NOW(a_split, out_tvalid, (out_tdata[29:24] == out_tdata[5:0]) && (out_tdata[23:15] == out_tdata[14:6]), "fwss: word/bit split mismatch")

  // reduction is registered, so no result can follow a request at once
  `FWSS_ASSERT_NEXT(a_no_early, in_tvalid && in_tready, !$rose(out_tvalid), "fwss: result too early after request")

  // positions lie below the vector length where the field holds them whole
  `FWSS_ASSERT_NOW(a_pos_range, out_tvalid, (VECTOR_LENGTH > 32768) || ({2'b00, out_tdata[14:0]} < 17'(VECTOR_LENGTH)), "fwss: position out of range")

endmodule

bind fixed_weight_support_sampler fwss_checker #(
  .VECTOR_LENGTH(VECTOR_LENGTH)
) u_fwss_checker (.*);
